FILE: hdl/assert_macros.svh
// Assertion macros shared by the timer table RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with a reset that disables checking.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must never hold outside reset.
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   `ASSERT_CLK(lbl, clk, rst, !(expr), msg)

`endif

FILE: hdl/twtt_pkg.sv
// Types and codes shared by the timing wheel timer table modules.
// Depends on nothing; imported by the controller, the datapath and the top level.
package twtt_pkg;

   typedef enum logic [1:0] {
      OP_ADD     = 2'd0,
      OP_REFRESH = 2'd1,
      OP_CANCEL  = 2'd2,
      OP_TICK    = 2'd3
   } op_type;

   localparam logic [2:0] KIND_DONE      = 3'd0;
   localparam logic [2:0] KIND_FIRED     = 3'd1;
   localparam logic [2:0] KIND_NOT_FOUND = 3'd2;
   localparam logic [2:0] KIND_FULL      = 3'd3;
   localparam logic [2:0] KIND_REPLACED  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LOAD,
      ST_REDUCE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic scan;
      logic load;
      logic reduce;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      op_type op;
      logic   scan_done;
      logic   found;
      logic   free;
      logic   sum_ge;
   } dp_status_type;

endpackage

FILE: hdl/twtt_ctrl.sv
// Sequencing state machine of the timer table: scan, deadline reduction, finish.
// Depends on twtt_pkg for the state, command and status types.
module twtt_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  twtt_pkg::dp_status_type   status,
   output twtt_pkg::ctl_cmd_type     cmd,
   output logic                      busy
);
   import twtt_pkg::*;

   state_type state_ff, state_in;
   logic      need_deadline;

   // Add with a target entry and refresh of a stored id compute a new deadline.
   assign need_deadline = ((status.op == OP_ADD) && (status.found || status.free)) ||
                          ((status.op == OP_REFRESH) && status.found);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_done) state_in = need_deadline ? ST_LOAD : ST_FINISH;
         end
         ST_LOAD: begin
            state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (!status.sum_ge) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd         = '0;
      busy        = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         ST_SCAN:   cmd.scan   = 1'b1;
         ST_LOAD:   cmd.load   = 1'b1;
         ST_REDUCE: cmd.reduce = 1'b1;
         ST_FINISH: cmd.finish = 1'b1;
         default:   busy       = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/twtt_datapath.sv
// Datapath of the timer table: entry memories, valid bits, scan pipeline,
// deadline reduction and result register. Depends on twtt_pkg.
module twtt_datapath #(
   parameter int WHEEL_SLOTS   = 64,
   parameter int TABLE_ENTRIES = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  twtt_pkg::ctl_cmd_type   cmd,
   output twtt_pkg::dp_status_type status,
   input  logic [1:0]              req_op,
   input  logic [31:0]             req_timer_id,
   input  logic [5:0]              req_timeout,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_kind,
   output logic [31:0]             rsp_fired_id,
   output logic                    rsp_last
);
   import twtt_pkg::*;

   localparam int TW = $clog2(WHEEL_SLOTS);
   localparam int SW = $clog2(WHEEL_SLOTS + 63);
   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   // Entry stores, each with one write and one registered read port.
   logic [31:0]   ident_mem_ff    [TABLE_ENTRIES];
   logic [5:0]    delay_mem_ff    [TABLE_ENTRIES];
   logic [TW-1:0] deadline_mem_ff [TABLE_ENTRIES];
   logic          cancel_mem_ff   [TABLE_ENTRIES];

   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;

   op_type        op_ff, op_in;
   logic [31:0]   id_ff, id_in;
   logic [5:0]    timeout_ff, timeout_in;
   logic [TW-1:0] tick_ff, tick_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          chk_ff, chk_in;
   logic [AW-1:0] chk_idx_ff, chk_idx_in;
   logic          found_ff, found_in;
   logic [AW-1:0] found_idx_ff, found_idx_in;
   logic [5:0]    found_delay_ff, found_delay_in;
   logic          free_ff, free_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_kind_ff, rsp_kind_in;
   logic [31:0]   rsp_id_ff, rsp_id_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [31:0]   rd_ident_ff;
   logic [TW-1:0] rd_deadline_ff;
   logic [5:0]    rd_delay_ff;
   logic          rd_cancel_ff;
   logic          rd_valid_ff;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic          we_ident, we_delay, we_deadline, we_cancel;
   logic          cancel_data;
   logic          sum_ge;
   logic [5:0]    delay_sel;

   assign rd_en     = cmd.scan && (rd_idx_ff != CW'(TABLE_ENTRIES));
   assign rd_addr   = rd_idx_ff[AW-1:0];
   assign sum_ge    = sum_ff >= SW'(WHEEL_SLOTS);
   assign delay_sel = (op_ff == OP_ADD) ? timeout_ff : found_delay_ff;
   assign wr_addr   = found_ff ? found_idx_ff : free_idx_ff;

   assign status.op        = op_ff;
   assign status.scan_done = (rd_idx_ff == CW'(TABLE_ENTRIES)) && !chk_ff;
   assign status.found     = found_ff;
   assign status.free      = free_ff;
   assign status.sum_ge    = sum_ge;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_fired_id = rsp_id_ff;
   assign rsp_last     = rsp_last_ff;

   always_comb begin
      op_in          = op_ff;
      id_in          = id_ff;
      timeout_in     = timeout_ff;
      tick_in        = tick_ff;
      rd_idx_in      = rd_idx_ff;
      chk_in         = 1'b0;
      chk_idx_in     = chk_idx_ff;
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      found_delay_in = found_delay_ff;
      free_in        = free_ff;
      free_idx_in    = free_idx_ff;
      sum_in         = sum_ff;
      valid_in       = valid_ff;
      rsp_valid_in   = 1'b0;
      rsp_kind_in    = rsp_kind_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_last_in    = rsp_last_ff;
      we_ident       = 1'b0;
      we_delay       = 1'b0;
      we_deadline    = 1'b0;
      we_cancel      = 1'b0;
      cancel_data    = 1'b0;

      if (cmd.capture) begin
         op_in      = op_type'(req_op);
         id_in      = req_timer_id;
         timeout_in = req_timeout;
         rd_idx_in  = '0;
         found_in   = 1'b0;
         free_in    = 1'b0;
         if (op_type'(req_op) == OP_TICK) begin
            tick_in = (tick_ff == TW'(WHEEL_SLOTS - 1)) ? '0 : tick_ff + 1'b1;
         end
      end

      if (rd_en) begin
         rd_idx_in  = rd_idx_ff + 1'b1;
         chk_in     = 1'b1;
         chk_idx_in = rd_addr;
      end

      // One entry read last cycle is examined here.
      if (chk_ff) begin
         if (op_ff == OP_TICK) begin
            if (rd_valid_ff && (rd_deadline_ff == tick_ff)) begin
               valid_in[chk_idx_ff] = 1'b0;
               if (!rd_cancel_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_FIRED;
                  rsp_id_in    = rd_ident_ff;
                  rsp_last_in  = 1'b0;
               end
            end
         end else begin
            if (rd_valid_ff && (rd_ident_ff == id_ff) && !found_ff) begin
               found_in       = 1'b1;
               found_idx_in   = chk_idx_ff;
               found_delay_in = rd_delay_ff;
            end
            if (!rd_valid_ff && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = chk_idx_ff;
            end
         end
      end

      if (cmd.load) begin
         sum_in = SW'(tick_ff) + SW'(delay_sel);
      end

      if (cmd.reduce && sum_ge) begin
         sum_in = sum_ff - SW'(WHEEL_SLOTS);
      end

      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = 1'b1;
         rsp_id_in    = id_ff;
         rsp_kind_in  = KIND_DONE;
         unique case (op_ff)
            OP_ADD: begin
               if (found_ff) begin
                  rsp_kind_in = KIND_REPLACED;
                  we_delay    = 1'b1;
                  we_deadline = 1'b1;
                  we_cancel   = 1'b1;
               end else if (free_ff) begin
                  valid_in[free_idx_ff] = 1'b1;
                  we_ident    = 1'b1;
                  we_delay    = 1'b1;
                  we_deadline = 1'b1;
                  we_cancel   = 1'b1;
               end else begin
                  rsp_kind_in = KIND_FULL;
               end
            end
            OP_REFRESH: begin
               if (found_ff) we_deadline = 1'b1;
               else          rsp_kind_in = KIND_NOT_FOUND;
            end
            OP_CANCEL: begin
               if (found_ff) begin
                  we_cancel   = 1'b1;
                  cancel_data = 1'b1;
               end else begin
                  rsp_kind_in = KIND_NOT_FOUND;
               end
            end
            OP_TICK: begin
               rsp_id_in = '0;
            end
            default: begin
               rsp_kind_in = KIND_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ident_ff    <= ident_mem_ff[rd_addr];
         rd_delay_ff    <= delay_mem_ff[rd_addr];
         rd_deadline_ff <= deadline_mem_ff[rd_addr];
         rd_cancel_ff   <= cancel_mem_ff[rd_addr];
         rd_valid_ff    <= valid_ff[rd_addr];
      end
      if (we_ident)    ident_mem_ff[wr_addr]    <= id_ff;
      if (we_delay)    delay_mem_ff[wr_addr]    <= timeout_ff;
      if (we_deadline) deadline_mem_ff[wr_addr] <= sum_ff[TW-1:0];
      if (we_cancel)   cancel_mem_ff[wr_addr]   <= cancel_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         tick_ff      <= '0;
         rd_idx_ff    <= '0;
         chk_ff       <= 1'b0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         op_ff        <= OP_TICK;
      end else begin
         valid_ff     <= valid_in;
         tick_ff      <= tick_in;
         rd_idx_ff    <= rd_idx_in;
         chk_ff       <= chk_in;
         found_ff     <= found_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         op_ff        <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff          <= id_in;
      timeout_ff     <= timeout_in;
      chk_idx_ff     <= chk_idx_in;
      found_idx_ff   <= found_idx_in;
      found_delay_ff <= found_delay_in;
      free_idx_ff    <= free_idx_in;
      sum_ff         <= sum_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_last_ff    <= rsp_last_in;
   end

endmodule

FILE: hdl/timing_wheel_timer_table.sv
// Top level of the hashed timing wheel timer table.
// Depends on twtt_pkg, twtt_ctrl, twtt_datapath and assert_macros.svh.
//
// A request is taken when start is high and busy is low; results come back on
// the rsp_ ports, each valid for exactly one cycle while rsp_valid is high, and
// the receiver cannot stall them, so it must take every strobed result. Add,
// refresh and cancel give one result with rsp_last set; a tick gives one fired
// result per expiring live timer, in table order, and then a done result with
// rsp_last set and rsp_fired_id zero. Every request walks the timer table one
// entry per cycle through the registered read port of the entry memories. An
// add that stores an entry and a refresh that finds its id also compute the
// new deadline modulo WHEEL_SLOTS by repeated subtraction: a load step, a
// subtraction step each time the sum reaches WHEEL_SLOTS, and a final check
// step. There is no clearing pass after reset; the valid bits clear at once.

`include "assert_macros.svh"

module timing_wheel_timer_table #(
   parameter int WHEEL_SLOTS   = 64,
   parameter int TABLE_ENTRIES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_timer_id,
   input  logic [5:0]  req_timeout,
   output logic        rsp_valid,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_fired_id,
   output logic        rsp_last
);
   import twtt_pkg::*;

   // Commands flow from the controller to the datapath, status flows back.
   ctl_cmd_type   cmd;
   dp_status_type status;

   twtt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   twtt_datapath #(
      .WHEEL_SLOTS   (WHEEL_SLOTS),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_op       (req_op),
      .req_timer_id (req_timer_id),
      .req_timeout  (req_timeout),
      .rsp_valid    (rsp_valid),
      .rsp_kind     (rsp_kind),
      .rsp_fired_id (rsp_fired_id),
      .rsp_last     (rsp_last)
   );

   // An accepted request keeps the block busy and shows no result in the next
   // cycle, since the first table read has not come back yet.
   `ASSERT_CLK(a_accept_busy, clock, reset, (start && !busy) |=> (busy && !rsp_valid), "accepted request did not start work")

   // Only fired results of a tick come without the last flag.
   `ASSERT_CLK(a_notlast_fired, clock, reset, (rsp_valid && !rsp_last) |-> (rsp_kind == KIND_FIRED), "non-final result is not a fired timer")

   // Fired results appear only while the block is still busy with the tick.
   `ASSERT_NEVER(a_fired_idle, clock, reset, rsp_valid && !rsp_last && !busy, "fired result outside a tick scan")

   // The final result of one request is never directly followed by another result.
   `ASSERT_CLK(a_last_gap, clock, reset, (rsp_valid && rsp_last) |=> !rsp_valid, "result right after a final result")

endmodule
